// ===== hdl/tvs_pkg.sv =====
package tvs_pkg;

    localparam int X_SIZE        = 32;
    localparam int Y_SIZE        = 32;
    localparam int Z_SIZE        = 32;
    localparam int FRACTION_BITS = 8;
    localparam int XB            = $clog2(X_SIZE);
    localparam int YB            = $clog2(Y_SIZE);
    localparam int ZB            = $clog2(Z_SIZE);
    localparam int BANK_DEPTH    = (X_SIZE / 2) * (Y_SIZE / 2) * (Z_SIZE / 2);
    localparam int BANK_AW       = XB + YB + ZB - 3;
    localparam int FW            = FRACTION_BITS + 1;
    localparam int SH            = 3 * FRACTION_BITS - 8;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_MIN   = 3'd0,
        REG_SCALE = 3'd1,
        REG_XEXT  = 3'd2,
        REG_YEXT  = 3'd3,
        REG_ZEXT  = 3'd4
    } reg_idx_t;

    // one classified request handed from front to back
    typedef struct packed {
        logic              is_sample;
        logic [XB-1:0]     bx;
        logic [YB-1:0]     by;
        logic [ZB-1:0]     bz;
        logic [FW-1:0]     fx;
        logic [FW-1:0]     fy;
        logic [FW-1:0]     fz;
        logic [XB-1:0]     wx;
        logic [YB-1:0]     wy;
        logic [ZB-1:0]     wz;
        logic [15:0]       wval;
    } tvs_req_t;

endpackage

// ===== hdl/tvs_ram.sv =====
module tvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/tvs_front.sv =====
module tvs_front import tvs_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          op,
    input  logic [4:0]    vx,
    input  logic [4:0]    vy,
    input  logic [4:0]    vz,
    input  logic [15:0]   vval,
    input  logic [12:0]   px,
    input  logic [12:0]   py,
    input  logic [12:0]   pz,
    output logic [15:0]   min_value,
    output logic [31:0]   scale,
    output logic          q_valid,
    input  logic          q_ready,
    output tvs_req_t      q_req
);
    logic [15:0] min_reg;
    logic [31:0] scale_reg;
    logic [5:0]  xe_reg, ye_reg, ze_reg;
    tvs_req_t    fifo_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    tvs_req_t    req;
    logic [XB-1:0] bx; logic [YB-1:0] by; logic [ZB-1:0] bz;
    logic [FW-1:0] fx, fy, fz;

    assign min_value = min_reg;
    assign scale     = scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= '0;
            scale_reg <= 32'd65537;
            xe_reg    <= 6'd32;
            ye_reg    <= 6'd32;
            ze_reg    <= 6'd32;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_MIN:   min_reg   <= cfg_data[15:0];
                REG_SCALE: scale_reg <= cfg_data;
                REG_XEXT:  xe_reg    <= cfg_data[5:0];
                REG_YEXT:  ye_reg    <= cfg_data[5:0];
                REG_ZEXT:  ze_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    function automatic logic [9+FW-1:0] locate(input logic [12:0] p, input logic [5:0] e,
                                               input int size);
        logic [8:0]  ext;
        logic [21:0] top;
        logic [8:0]  b;
        logic [FW-1:0] f;
        if (e < 6'd2) ext = 9'd2;
        else if (32'(e) > size) ext = 9'(size);
        else ext = 9'(e);
        top = 22'(ext - 9'd1) << FRACTION_BITS;
        if (22'(p) >= top) begin
            b = ext - 9'd2;
            f = FW'(1) << FRACTION_BITS;
        end else begin
            b = 9'(p >> FRACTION_BITS);
            f = FW'(p[FRACTION_BITS-1:0]);
        end
        locate = {b, f};
    endfunction

    always_comb begin
        logic [9+FW-1:0] lx, ly, lz;
        lx = locate(px, xe_reg, X_SIZE);
        ly = locate(py, ye_reg, Y_SIZE);
        lz = locate(pz, ze_reg, Z_SIZE);
        bx = lx[XB+FW-1:FW]; fx = lx[FW-1:0];
        by = ly[YB+FW-1:FW]; fy = ly[FW-1:0];
        bz = lz[ZB+FW-1:FW]; fz = lz[FW-1:0];
        req.is_sample = (op_t'(op) == OP_SAMPLE);
        req.bx = bx; req.by = by; req.bz = bz;
        req.fx = fx; req.fy = fy; req.fz = fz;
        req.wx = XB'(vx); req.wy = YB'(vy); req.wz = ZB'(vz);
        req.wval = vval;
    end

    // two-entry queue towards the back end
    logic push, pop;
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = fifo_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wp_reg] <= req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== hdl/tvs_back.sv =====
module tvs_back import tvs_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [15:0]   min_value,
    input  logic [31:0]   scale,
    input  logic          q_valid,
    output logic          q_ready,
    input  tvs_req_t      q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   out_value,
    output logic          out_sat
);
    localparam int NST = 5;
    localparam int AW  = 16 + 3 * FW;
    localparam int LX  = 16 + FW;
    localparam int LY  = 16 + 2 * FW;

    logic [NST-1:0] v_reg;
    logic           adv;
    logic           ov_reg;
    logic [15:0]    oval_reg;
    logic           osat_reg;

    // pipeline moves when the output register is free or being emptied
    assign adv       = !ov_reg || out_ready;
    assign q_ready   = adv;
    assign out_valid = ov_reg;
    assign out_value = oval_reg;
    assign out_sat   = osat_reg;

    // bank addressing: bank = parity of (x,y,z), address = halved indices
    logic [BANK_AW-1:0] raddr [8];
    logic [15:0]        rdata [8];
    logic [2:0]         wbank;
    logic [BANK_AW-1:0] waddr;
    logic               wen;

    assign wen   = q_valid && adv && !q_req.is_sample;
    assign wbank = {q_req.wz[0], q_req.wy[0], q_req.wx[0]};
    assign waddr = {q_req.wz[ZB-1:1], q_req.wy[YB-1:1], q_req.wx[XB-1:1]};

    logic [2:0] selb_reg;
    logic [FW-1:0] fx1_reg, fy1_reg, fz1_reg;

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [XB-1:0] cx; logic [YB-1:0] cy; logic [ZB-1:0] cz;
        always_comb begin
            // corner coordinate whose parity is that of bank b
            cx = q_req.bx + XB'(b[0] ^ q_req.bx[0]);
            cy = q_req.by + YB'(b[1] ^ q_req.by[0]);
            cz = q_req.bz + ZB'(b[2] ^ q_req.bz[0]);
            raddr[b] = {cz[ZB-1:1], cy[YB-1:1], cx[XB-1:1]};
        end
        tvs_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_ram (
            .aclk (aclk),
            .we   (wen && (wbank == 3'(b))),
            .waddr(waddr),
            .wdata(q_req.wval),
            .re   (adv),
            .raddr(raddr[b]),
            .rdata(rdata[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            selb_reg <= {q_req.bz[0], q_req.by[0], q_req.bx[0]};
            fx1_reg <= q_req.fx; fy1_reg <= q_req.fy; fz1_reg <= q_req.fz;
        end
    end

    // stage 2: x lerps
    logic [LX-1:0] lx_reg [4];
    logic [FW-1:0] fy2_reg, fz2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                logic [15:0] a, c;
                a = rdata[3'({k[1], k[0], 1'b0}) ^ selb_reg];
                c = rdata[3'({k[1], k[0], 1'b1}) ^ selb_reg];
                lx_reg[k] <= LX'(a) * LX'((FW'(1) << FRACTION_BITS) - fx1_reg)
                           + LX'(c) * LX'(fx1_reg);
            end
            fy2_reg <= fy1_reg; fz2_reg <= fz1_reg;
        end
    end

    // stage 3: y lerps (k = {dz,dy})
    logic [LY-1:0] ly_reg [2];
    logic [FW-1:0] fz3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int d = 0; d < 2; d++) begin
                ly_reg[d] <= LY'(lx_reg[2*d]) * LY'((FW'(1) << FRACTION_BITS) - fy2_reg)
                           + LY'(lx_reg[2*d+1]) * LY'(fy2_reg);
            end
            fz3_reg <= fz2_reg;
        end
    end

    // stage 4: z lerp, rounding, minus offset
    logic signed [25:0] d4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [AW-1:0] acc;
            logic [AW-1:0] vq;
            acc = AW'(ly_reg[0]) * AW'((FW'(1) << FRACTION_BITS) - fz3_reg)
                + AW'(ly_reg[1]) * AW'(fz3_reg);
            vq = (acc + (AW'(1) << (SH - 1))) >> SH;
            d4_reg <= $signed({1'b0, vq[24:0]}) - $signed({2'b0, min_value, 8'b0});
        end
    end

    // stage 5: scale multiply
    logic signed [58:0] t5_reg;
    always_ff @(posedge aclk) begin
        if (adv) t5_reg <= 59'(d4_reg) * $signed({1'b0, scale});
    end

    // stage 6: offset, round, saturate into output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [59:0] t;
            logic signed [33:0] r;
            t = 60'(t5_reg) - (60'sd1 <<< 39) + (60'sd1 <<< 25);
            r = t[59:26];
            if (r > 34'sd32767) begin
                oval_reg <= 16'h7FFF; osat_reg <= 1'b1;
            end else if (r < -34'sd32768) begin
                oval_reg <= 16'h8000; osat_reg <= 1'b1;
            end else begin
                oval_reg <= r[15:0]; osat_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            v_reg  <= {v_reg[NST-2:0], q_valid && q_req.is_sample};
            ov_reg <= v_reg[NST-1];
        end
    end
endmodule

// ===== hdl/trilinear_volume_sampler.sv =====
// channel   | direction | tdata fields (low bit up)                              | tuser
// s_axis    | in        | vx[4:0] vy[9:5] vz[14:10] value[30:15] px[43:31]      | operation
//           |           | py[56:44] pz[69:57], zero fill to 72                  |
// m_axis    | out       | field_value[15:0]                                      | saturated
// cfg       | in        | cfg_we, cfg_index, cfg_data[31:0]                      | -
// One request per cycle sustained while m_ tready does not stall. A sample taken
// on s_ passes the queue, then the eight corners from eight parity banks in one
// registered read, one multiply stage per axis, the normalize multiply and
// rounding into the output register, where m_tvalid rises.
// Reset (aresetn, synchronous, active low) sets registers to defaults; voxels
// are undefined until written. A stalled m_ tready freezes the back pipeline;
// the two-entry queue holds s_ side requests meanwhile.
module trilinear_volume_sampler import tvs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // voxel_x, voxel_y, voxel_z, voxel_value, point_x/y/z
    input  logic        s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // field_value
    output logic        m_tuser   // saturated
);
    logic [15:0] min_value;
    logic [31:0] scale;
    logic        q_valid, q_ready;
    tvs_req_t    q_req;

    tvs_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .in_valid(s_tvalid), .in_ready(s_tready), .op(s_tuser),
        .vx(s_tdata[4:0]), .vy(s_tdata[9:5]), .vz(s_tdata[14:10]),
        .vval(s_tdata[30:15]), .px(s_tdata[43:31]), .py(s_tdata[56:44]),
        .pz(s_tdata[69:57]), .min_value, .scale, .q_valid, .q_ready, .q_req
    );

    tvs_back u_back (
        .aclk, .aresetn, .min_value, .scale, .q_valid, .q_ready, .q_req,
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_value(m_tdata), .out_sat(m_tuser)
    );
endmodule

// ===== verif/volume_checker.sv =====
module volume_checker import tvs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] field;
        logic        sat;
    } field_result_t;

    field_result_t field_q[$];
    logic [15:0]   voxel_mem [X_SIZE*Y_SIZE*Z_SIZE];
    logic [15:0]   min_reg;
    logic [31:0]   scale_reg;
    logic [5:0]    xext_reg, yext_reg, zext_reg;

    function automatic void axis_pos(input longint p, input longint ext_reg, input int size,
                                     output int base, output longint frac);
        longint ext;
        ext = (ext_reg < 2) ? 2 : (ext_reg > size) ? size : ext_reg;
        if (p >= ((ext - 1) << FRACTION_BITS)) begin
            base = int'(ext) - 2;
            frac = longint'(1) << FRACTION_BITS;
        end else begin
            base = int'(p >> FRACTION_BITS);
            frac = p & ((longint'(1) << FRACTION_BITS) - 1);
        end
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint f);
        return a * ((longint'(1) << FRACTION_BITS) - f) + b * f;
    endfunction

    function automatic longint voxel(input int x, input int y, input int z);
        return longint'(voxel_mem[(z * Y_SIZE + y) * X_SIZE + x]);
    endfunction

    function automatic field_result_t interpolate(input logic [12:0] px, py, pz);
        int            bx, by, bz;
        longint        fx, fy, fz, acc, vq, t, r;
        longint        lx [2][2];
        longint        ly [2];
        field_result_t res;
        axis_pos(px, xext_reg, X_SIZE, bx, fx);
        axis_pos(py, yext_reg, Y_SIZE, by, fy);
        axis_pos(pz, zext_reg, Z_SIZE, bz, fz);
        for (int dz = 0; dz < 2; dz++)
            for (int dy = 0; dy < 2; dy++)
                lx[dz][dy] = mix(voxel(bx, by + dy, bz + dz), voxel(bx + 1, by + dy, bz + dz), fx);
        for (int dz = 0; dz < 2; dz++)
            ly[dz] = mix(lx[dz][0], lx[dz][1], fy);
        acc = mix(ly[0], ly[1], fz);
        vq  = (acc + (longint'(1) << (SH - 1))) >> SH;
        t   = (vq - longint'(min_reg) * 256) * longint'(scale_reg) - (longint'(1) << 39);
        r   = (t + (longint'(1) << 25)) >>> 26;
        res.sat = 1'b0;
        if (r > 32767) begin
            r = 32767;
            res.sat = 1'b1;
        end
        if (r < -32768) begin
            r = -32768;
            res.sat = 1'b1;
        end
        res.field = r[15:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        field_result_t want;
        if (!aresetn) begin
            min_reg      = '0;
            scale_reg    = 32'd65537;
            xext_reg     = 6'd32;
            yext_reg     = 6'd32;
            zext_reg     = 6'd32;
            field_q.delete();
            fail_count   = 0;
            results_seen = 0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_index))
                    REG_MIN:   min_reg   = cfg_data[15:0];
                    REG_SCALE: scale_reg = cfg_data;
                    REG_XEXT:  xext_reg  = cfg_data[5:0];
                    REG_YEXT:  yext_reg  = cfg_data[5:0];
                    REG_ZEXT:  zext_reg  = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (field_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result %h sat %b", $realtime, m_tdata, m_tuser);
                end else begin
                    want = field_q.pop_front();
                    if (m_tdata !== want.field || m_tuser !== want.sat) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: expected %h sat %b, got %h sat %b", $realtime,
                                     want.field, want.sat, m_tdata, m_tuser);
                    end
                end
            end
            // sample sees every write accepted before it
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser) == OP_SAMPLE)
                    field_q.push_back(interpolate(s_tdata[43:31], s_tdata[56:44], s_tdata[69:57]));
                else
                    voxel_mem[(s_tdata[14:10] * Y_SIZE + s_tdata[9:5]) * X_SIZE + s_tdata[4:0]]
                        = s_tdata[30:15];
            end
        end
        pending = field_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench import tvs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    int          fail_count, pending, results_seen;

    // stimulus side state
    bit          written_map [X_SIZE*Y_SIZE*Z_SIZE];
    logic [5:0]  ext_now [3];
    bit          no_gaps  = 1'b0;  // back-to-back stretches on both sides
    bit          hold_off = 1'b0;  // asks the receiver for one long stall
    int          writes_sent, samples_sent;

    always #5 aclk = ~aclk;

    trilinear_volume_sampler u_dut (.*);

    volume_checker u_check (.*);

    initial begin
        #5ms;
        $display("timeout");
        $display("trilinear_volume_sampler verification failed");
        $finish;
    end

    // receiver: random stall per result, plus the one long hold-off
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            w = no_gaps ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                m_tready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one request on s_; unused fields carry random junk
    task automatic send_req(input op_t op, input logic [4:0] vx, vy, vz, input logic [15:0] val,
                            input logic [12:0] px, py, pz);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {2'b00, pz, py, px, val, vz, vy, vx};
        s_tuser  = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_voxel(input int x, y, z, input logic [15:0] val);
        written_map[(z * Y_SIZE + y) * X_SIZE + x] = 1'b1;
        writes_sent++;
        send_req(OP_WRITE, 5'(x), 5'(y), 5'(z), val, 13'($urandom), 13'($urandom),
                 13'($urandom));
    endtask

    function automatic int cell_base(input int p, input int axis, input int size);
        int ext;
        ext = (ext_now[axis] < 2) ? 2 : (ext_now[axis] > size) ? size : ext_now[axis];
        return (p >= ((ext - 1) << FRACTION_BITS)) ? ext - 2 : p >> FRACTION_BITS;
    endfunction

    // fills any unwritten corner of the cell first, then samples
    task automatic sample_point(input int px, py, pz);
        int bx, by, bz;
        bx = cell_base(px, 0, X_SIZE);
        by = cell_base(py, 1, Y_SIZE);
        bz = cell_base(pz, 2, Z_SIZE);
        for (int c = 0; c < 8; c++)
            if (!written_map[((bz + c[2]) * Y_SIZE + by + c[1]) * X_SIZE + bx + c[0]])
                write_voxel(bx + c[0], by + c[1], bz + c[2], 16'($urandom));
        samples_sent++;
        send_req(OP_SAMPLE, 5'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                 13'(px), 13'(py), 13'(pz));
    endtask

    function automatic int rand_point(input int axis);
        int ext;
        ext = (ext_now[axis] < 2) ? 2 : (ext_now[axis] > 32) ? 32 : ext_now[axis];
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 8191);
            1:       return $urandom_range(0, (ext - 1) << FRACTION_BITS);
            2:       return ((ext - 1) << FRACTION_BITS) - $urandom_range(0, 3);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic settle();
        wait (pending == 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == REG_XEXT) ext_now[0] = val[5:0];
        if (idx == REG_YEXT) ext_now[1] = val[5:0];
        if (idx == REG_ZEXT) ext_now[2] = val[5:0];
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // all five registers; junk above each register's width
    task automatic set_all(input logic [15:0] mn, input logic [31:0] sc,
                           input logic [5:0] ex, ey, ez);
        settle();
        write_reg(REG_MIN,   {16'($urandom), mn});
        write_reg(REG_SCALE, sc);
        write_reg(REG_XEXT,  {26'($urandom), ex});
        write_reg(REG_YEXT,  {26'($urandom), ey});
        write_reg(REG_ZEXT,  {26'($urandom), ez});
    endtask

    task automatic random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                write_voxel($urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 31), 16'($urandom));
            else
                sample_point(rand_point(0), rand_point(1), rand_point(2));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        ext_now = '{6'd32, 6'd32, 6'd32};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: default range, value extremes, corners and the clamped top cell
        set_all(16'd0, 32'd65537, 6'd32, 6'd32, 6'd32);
        write_voxel(0, 0, 0, 16'h0000);
        write_voxel(1, 0, 0, 16'hFFFF);
        write_voxel(0, 1, 0, 16'hFFFF);
        write_voxel(1, 1, 0, 16'h0000);
        write_voxel(0, 0, 1, 16'h8000);
        write_voxel(1, 0, 1, 16'h7FFF);
        write_voxel(0, 1, 1, 16'hFFFF);
        write_voxel(1, 1, 1, 16'hFFFF);
        sample_point(0, 0, 0);
        sample_point(128, 128, 128);
        sample_point(255, 1, 254);
        sample_point(256, 0, 0);
        sample_point(8191, 8191, 8191);
        sample_point(31 << 8, 7936 - 1, 0);
        write_voxel(31, 31, 31, 16'hFFFF);
        sample_point(8191, 8191, 8191);
        random_mix(48);

        // lowest extents, min at top, zero scale: everything pins to minus one half
        set_all(16'hFFFF, 32'd0, 6'd2, 6'd2, 6'd2);
        sample_point(0, 0, 0);
        sample_point(8191, 8191, 8191);
        random_mix(24);

        // extents below 2 and above the size; huge scale saturates both ways
        set_all(16'd1000, 32'hFFFF_FFFF, 6'd0, 6'd63, 6'd5);
        write_voxel(0, 0, 0, 16'd1000);
        sample_point(0, 0, 0);
        random_mix(32);
        set_all(16'd0, 32'h8000_0000, 6'd1, 6'd33, 6'd2);
        random_mix(24);

        // sender waits for an empty pipe mid-stream
        for (int ph = 0; ph < 3; ph++) begin
            set_all(16'($urandom_range(0, 30000)), 32'($urandom_range(1 << 16, 1 << 20)),
                    6'($urandom_range(2, 32)), 6'($urandom_range(2, 32)),
                    6'($urandom_range(2, 32)));
            random_mix(20);
            wait (pending == 0);
            random_mix(12);
        end

        // receiver stalls for a long stretch while requests keep coming
        set_all(16'd0, 32'd65537, 6'd32, 6'd32, 6'd32);
        no_gaps  = 1'b1;
        hold_off = 1'b1;
        for (int i = 0; i < 24; i++)
            sample_point(rand_point(0), rand_point(1), rand_point(2));
        no_gaps = 1'b0;
        random_mix(24);

        settle();
        $display("%0d voxel writes, %0d samples, %0d results over eight register settings",
                 writes_sent, samples_sent, results_seen);
        $display("extents 0 to 63, scale 0 to max, saturation both ways, one 300-cycle stall");
        if (fail_count == 0)
            $display("trilinear_volume_sampler verification clean");
        else
            $display("trilinear_volume_sampler verification failed");
        $finish;
    end

endmodule
